### sv/mpq_pkg.sv
`timescale 1ns / 1ps
// mpq_pkg: sizes, command and status codes, and control structs for the
// multilevel priority queue. No dependencies.
package mpq_pkg;

   // sizing
   localparam int NUM_LEVELS  = 8;
   localparam int LEVEL_DEPTH = 16;
   localparam int ID_WIDTH    = 16;

   // fixed field widths of the channels
   localparam int OP_W      = 2;
   localparam int TASK_W    = 16;
   localparam int PRI_W     = 4;
   localparam int STATUS_W  = 2;

   // derived widths
   localparam int LVL_W       = $clog2(NUM_LEVELS);
   localparam int PTR_W       = $clog2(LEVEL_DEPTH);
   localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // command codes
   localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd1;
   localparam logic [OP_W-1:0] OP_DEQ  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic exec;    // beat accepted: decide, touch store, update pointers
      logic finish;  // store data ready: load the result register
   } mpq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_busy;  // result register holds an untaken beat
   } mpq_stat_type;

endpackage

### sv/mpq_if.sv
`timescale 1ns / 1ps
// mpq_req_if / mpq_rsp_if: valid-ready channels of the priority queue.
// Depends on mpq_pkg.

// command channel
interface mpq_req_if;
   logic                         valid;
   logic                         ready;
   logic [mpq_pkg::OP_W-1:0]     opcode;
   logic [mpq_pkg::TASK_W-1:0]   task_id;
   logic [mpq_pkg::PRI_W-1:0]    priority_req;

   modport source (output valid, output opcode, output task_id,
                   output priority_req, input ready);
   modport sink   (input valid, input opcode, input task_id,
                   input priority_req, output ready);
endinterface

// result channel
interface mpq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mpq_pkg::STATUS_W-1:0]  status;
   logic [mpq_pkg::TASK_W-1:0]    out_task_id;
   logic [mpq_pkg::PRI_W-1:0]     out_priority;
   logic                          all_empty;

   modport source (output valid, output status, output out_task_id,
                   output out_priority, output all_empty, input ready);
   modport sink   (input valid, input status, input out_task_id,
                   input out_priority, input all_empty, output ready);
endinterface

### sv/mpq_ram.sv
`timescale 1ns / 1ps
// mpq_ram: generic single-port RAM with registered read data.
// No dependencies.
module mpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/mpq_ctrl.sv
`timescale 1ns / 1ps
// mpq_ctrl: two-state sequencer of the priority queue.
// Depends on mpq_pkg.
module mpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   input  mpq_pkg::mpq_stat_type stat,
   output mpq_pkg::mpq_cmd_type  cmd
);
   import mpq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DONE = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // take a beat when idle and the result register is free or draining
   assign req_ready = (state_ff == S_IDLE) && (!stat.rsp_busy || rsp_ready);
   assign accept    = req_ready && req_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign cmd.exec   = accept;
   assign cmd.finish = (state_ff == S_DONE);

endmodule

### sv/mpq_datapath.sv
`timescale 1ns / 1ps
// mpq_datapath: level counters, head and tail pointers, task store and
// result register of the priority queue. Depends on mpq_pkg and mpq_ram.
module mpq_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  mpq_pkg::mpq_cmd_type           cmd,
   output mpq_pkg::mpq_stat_type          stat,
   input  logic [mpq_pkg::OP_W-1:0]       req_opcode,
   input  logic [mpq_pkg::TASK_W-1:0]     req_task_id,
   input  logic [mpq_pkg::PRI_W-1:0]      req_priority,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [mpq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mpq_pkg::TASK_W-1:0]     rsp_task_id,
   output logic [mpq_pkg::PRI_W-1:0]      rsp_priority,
   output logic                           rsp_all_empty
);
   import mpq_pkg::*;

   logic [CNT_W-1:0]    count_ff [NUM_LEVELS];
   logic [PTR_W-1:0]    head_ff  [NUM_LEVELS];
   logic [PTR_W-1:0]    tail_ff  [NUM_LEVELS];

   logic [NUM_LEVELS-1:0] busy;
   logic                  any_busy;
   logic [LVL_W-1:0]      sel_lvl;
   logic [LVL_W-1:0]      enq_lvl;
   logic                  pri_bad;
   logic                  lvl_full;

   logic                  do_enq;
   logic                  do_read;
   logic                  do_deq;
   logic [STATUS_W-1:0]   status_in;
   logic [PTR_W-1:0]      tail_cur;
   logic [PTR_W-1:0]      head_cur;
   logic [ADDR_W-1:0]     ram_addr;
   logic [ID_WIDTH-1:0]   ram_rdata;

   logic [STATUS_W-1:0]   pend_status_ff;
   logic                  pend_hit_ff;
   logic [LVL_W-1:0]      pend_lvl_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [TASK_W-1:0]     rsp_task_ff;
   logic [PRI_W-1:0]      rsp_pri_ff;
   logic                  rsp_empty_ff;

   // pointer step with wrap at the level depth
   function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] q;
      if (p == PTR_W'(LEVEL_DEPTH - 1)) q = '0;
      else q = p + PTR_W'(1);
      return q;
   endfunction

   // most urgent non-empty level
   always_comb begin
      sel_lvl = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         busy[i] = (count_ff[i] != '0);
         if (busy[i]) sel_lvl = LVL_W'(i);
      end
   end
   assign any_busy = |busy;

   // enqueue level and its checks
   assign pri_bad  = (req_priority == '0) || (req_priority > PRI_W'(NUM_LEVELS));
   assign enq_lvl  = LVL_W'(req_priority - PRI_W'(1));
   assign lvl_full = (count_ff[enq_lvl] == CNT_W'(LEVEL_DEPTH));
   assign tail_cur = tail_ff[enq_lvl];
   assign head_cur = head_ff[sel_lvl];

   // command decode
   always_comb begin
      do_enq    = 1'b0;
      do_read   = 1'b0;
      do_deq    = 1'b0;
      status_in = ST_OK;
      case (req_opcode)
         OP_ENQ: begin
            if (pri_bad) begin
               status_in = ST_RANGE;
            end else if (lvl_full) begin
               status_in = ST_FULL;
            end else begin
               do_enq = cmd.exec;
            end
         end
         OP_PEEK, OP_DEQ: begin
            if (!any_busy) begin
               status_in = ST_EMPTY;
            end else begin
               do_read = cmd.exec;
               do_deq  = cmd.exec && (req_opcode == OP_DEQ);
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   // store address: level base plus slot
   always_comb begin
      if (do_enq) begin
         ram_addr = ADDR_W'(ADDR_W'(enq_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_cur));
      end else begin
         ram_addr = ADDR_W'(ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(head_cur));
      end
   end

   mpq_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .en    (do_enq || do_read),
      .we    (do_enq),
      .addr  (ram_addr),
      .wdata (ID_WIDTH'(req_task_id)),
      .rdata (ram_rdata)
   );

   // counters and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
         end
      end else begin
         if (do_enq) begin
            count_ff[enq_lvl] <= count_ff[enq_lvl] + CNT_W'(1);
            tail_ff[enq_lvl]  <= step_ptr(tail_cur);
         end
         if (do_deq) begin
            count_ff[sel_lvl] <= count_ff[sel_lvl] - CNT_W'(1);
            head_ff[sel_lvl]  <= step_ptr(head_cur);
         end
      end
   end

   // pending result fields while the store read is in flight
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pend_status_ff <= status_in;
         pend_hit_ff    <= do_read;
         pend_lvl_ff    <= sel_lvl;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= pend_status_ff;
         rsp_task_ff   <= pend_hit_ff ? TASK_W'(ram_rdata) : '0;
         rsp_pri_ff    <= pend_hit_ff ? PRI_W'(PRI_W'(pend_lvl_ff) + PRI_W'(1)) : '0;
         rsp_empty_ff  <= !any_busy;
      end
   end

   assign stat.rsp_busy = rsp_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_task_id   = rsp_task_ff;
   assign rsp_priority  = rsp_pri_ff;
   assign rsp_all_empty = rsp_empty_ff;

`ifndef SYNTHESIS
   // result register is free when a result is loaded
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff)
      else $error("result loaded over an untaken beat");

   // a loaded result shows up as valid
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("result not presented after load");

   // an empty report means every level is empty
   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> rsp_empty_ff)
      else $error("empty status with a non-empty queue");

   // a returned task always comes with an ok status
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pri_ff != '0) |-> (rsp_status_ff == ST_OK))
      else $error("task returned with an error status");
`endif

endmodule

### sv/multilevel_priority_queue_top.sv
`timescale 1ns / 1ps
// multilevel_priority_queue_top: eight-level priority FIFO of task ids.
// The command beat is registered into the store read and the pending fields,
// then loaded into the result register. No new command is taken while one is
// in flight through the single-port task store, whose registered read data is
// loaded into the result register; an untaken result holds off the next command
// until it is taken.
// Reset (synchronous): clears level counts, pointers, sequencer and result valid;
// the task store is not cleared and needs no clearing pass.
module multilevel_priority_queue_top (
   input  logic     clock,
   input  logic     reset,
   mpq_req_if.sink  req_chan,
   mpq_rsp_if.source rsp_chan
);
   import mpq_pkg::*;

   mpq_cmd_type  cmd;
   mpq_stat_type stat;

   // sequencer
   mpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // queue state and result register
   mpq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_opcode    (req_chan.opcode),
      .req_task_id   (req_chan.task_id),
      .req_priority  (req_chan.priority_req),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_status    (rsp_chan.status),
      .rsp_task_id   (rsp_chan.out_task_id),
      .rsp_priority  (rsp_chan.out_priority),
      .rsp_all_empty (rsp_chan.all_empty)
   );

endmodule

### sim/multilevel_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// multilevel_priority_queue_top_tb: self-checking bench for the eight-level priority
// task queue, with a cycle-free predictor of the level fifos and random stalls on both channels.
// Depends on mpq_pkg, mpq_req_if / mpq_rsp_if and multilevel_priority_queue_top.
module multilevel_priority_queue_top_tb;
   import mpq_pkg::*;

   // opcode 3 is unused by the block and answered with no change
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TASK_W-1:0]   task_id;
      logic [PRI_W-1:0]    level;
      logic                all_empty;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpq_req_if req_bus ();
   mpq_rsp_if rsp_bus ();

   multilevel_priority_queue_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the level fifos
   logic [ID_WIDTH-1:0] slot_ids [NUM_LEVELS][LEVEL_DEPTH];
   logic [PTR_W-1:0]    head_idx [NUM_LEVELS];
   logic [PTR_W-1:0]    tail_idx [NUM_LEVELS];
   logic [CNT_W-1:0]    level_fill [NUM_LEVELS];

   queue_reply_type pending_replies [$];
   int              err_count = 0;
   bit              quiet = 1'b0;

   // most urgent level holding a task, NUM_LEVELS when all are empty
   function automatic int first_busy_level();
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (level_fill[l] != '0) return l;
      end
      return NUM_LEVELS;
   endfunction

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (int'(p) + 1 >= LEVEL_DEPTH) ? '0 : p + 1'b1;
   endfunction

   // apply one command to the fifo copy and return the reply it should get
   function automatic queue_reply_type predict_reply(input logic [OP_W-1:0] op,
                                                     input logic [TASK_W-1:0] id,
                                                     input logic [PRI_W-1:0] pri);
      queue_reply_type r;
      int              l;
      r = '0;
      r.status = ST_OK;
      if (op == OP_ENQ) begin
         if (pri == '0 || int'(pri) > NUM_LEVELS) begin
            r.status = ST_RANGE;
         end else begin
            l = int'(pri) - 1;
            if (int'(level_fill[l]) >= LEVEL_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               slot_ids[l][tail_idx[l]] = id[ID_WIDTH-1:0];
               tail_idx[l] = next_slot(tail_idx[l]);
               level_fill[l] = level_fill[l] + 1'b1;
            end
         end
      end else if (op == OP_PEEK || op == OP_DEQ) begin
         l = first_busy_level();
         if (l >= NUM_LEVELS) begin
            r.status = ST_EMPTY;
         end else begin
            r.task_id = TASK_W'(slot_ids[l][head_idx[l]]);
            r.level   = PRI_W'(l + 1);
            if (op == OP_DEQ) begin
               head_idx[l] = next_slot(head_idx[l]);
               level_fill[l] = level_fill[l] - 1'b1;
            end
         end
      end
      r.all_empty = (first_busy_level() >= NUM_LEVELS);
      return r;
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // send one command beat, called and returning at a falling edge
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] id,
                           input logic [PRI_W-1:0] pri);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.opcode       = op;
      req_bus.task_id      = id;
      req_bus.priority_req = pri;
      do @(posedge clock); while (!req_bus.ready);
      pending_replies.push_back(predict_reply(op, id, pri));
      @(negedge clock);
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         err_count++;
      end
   endtask

   // compare each result beat with the oldest expected reply
   always @(posedge clock) begin
      queue_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual status %0d id %0h",
                     $time, rsp_bus.status, rsp_bus.out_task_id);
            err_count++;
         end else begin
            want = pending_replies.pop_front();
            report_field("status", want.status, rsp_bus.status);
            report_field("out_task_id", want.task_id, rsp_bus.out_task_id);
            report_field("out_priority", want.level, rsp_bus.out_priority);
            report_field("all_empty", want.all_empty, rsp_bus.all_empty);
         end
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("multilevel_priority_queue_top_tb NOT OK");
      $finish;
   end

   // peek, dequeue and unused opcode on an empty queue
   task automatic test_empty_queue();
      send_cmd(OP_PEEK, 16'h1234, 4'd1);
      send_cmd(OP_DEQ, 16'hFFFF, 4'd15);
      send_cmd(OP_NONE, 16'hFFFF, 4'd15);
   endtask

   // priorities 0 and above the top level store nothing
   task automatic test_bad_priority();
      send_cmd(OP_ENQ, 16'hBEEF, 4'd0);
      send_cmd(OP_ENQ, 16'h0001, PRI_W'(NUM_LEVELS + 1));
      send_cmd(OP_ENQ, 16'hFFFF, 4'd15);
   endtask

   // lowest level wins, fifo order inside a level, id extremes
   task automatic test_priority_order();
      send_cmd(OP_ENQ, 16'hFFFF, PRI_W'(NUM_LEVELS));
      send_cmd(OP_ENQ, 16'h0000, 4'd1);
      send_cmd(OP_ENQ, 16'hA5C3, 4'd1);
      send_cmd(OP_PEEK, 16'h0000, 4'd0);
      send_cmd(OP_NONE, 16'h5A5A, 4'd8);
      send_cmd(OP_DEQ, 16'h0000, 4'd0);
      send_cmd(OP_DEQ, 16'hFFFF, 4'd15);
      send_cmd(OP_DEQ, 16'h0000, 4'd0);
      send_cmd(OP_DEQ, 16'h0000, 4'd0);
   endtask

   // fill one level past full, then drain every level, pointers wrap over rounds
   task automatic test_fill_and_drain(input int rounds);
      int lvl;
      int n;
      for (int k = 0; k < rounds; k++) begin
         lvl = $urandom_range(1, NUM_LEVELS);
         n = LEVEL_DEPTH - int'(level_fill[lvl-1]) + $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0)
               send_cmd(OP_PEEK, 16'($urandom), 4'($urandom));
            send_cmd(OP_ENQ, 16'($urandom), PRI_W'(lvl));
         end
         while (first_busy_level() < NUM_LEVELS) begin
            if ($urandom_range(0, 4) == 0)
               send_cmd(OP_PEEK, 16'($urandom), 4'($urandom));
            send_cmd(OP_DEQ, 16'($urandom), 4'($urandom));
         end
         send_cmd(OP_DEQ, 16'($urandom), 4'($urandom));
      end
   endtask

   // random commands in blocks that lean toward filling or draining
   task automatic test_random_mix(input int blocks, input int per_block);
      int enq_pct;
      int hot;
      int r;
      logic [OP_W-1:0]  op;
      logic [PRI_W-1:0] pri;
      for (int b = 0; b < blocks; b++) begin
         enq_pct = (b % 2 == 0) ? 65 : 30;
         hot     = $urandom_range(1, NUM_LEVELS);
         quiet   = (b % 4 == 3);
         for (int i = 0; i < per_block; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
               op = OP_NONE;
            else if (r < 3 + enq_pct)
               op = OP_ENQ;
            else if (r < 3 + enq_pct + (97 - enq_pct) / 3)
               op = OP_PEEK;
            else
               op = OP_DEQ;
            r = $urandom_range(0, 99);
            if (r < 10) begin
               r = $urandom_range(0, 7);
               pri = (r == 0) ? 4'd0 : PRI_W'(NUM_LEVELS + r);
            end else if (r < 55) begin
               pri = PRI_W'(hot);
            end else begin
               pri = PRI_W'($urandom_range(1, NUM_LEVELS));
            end
            send_cmd(op, 16'($urandom), pri);
         end
      end
      quiet = 1'b0;
   endtask

   // reset, tests in turn, then wait out the last results
   initial begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         head_idx[l]   = '0;
         tail_idx[l]   = '0;
         level_fill[l] = '0;
      end
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OP_ENQ;
      req_bus.task_id      = '0;
      req_bus.priority_req = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_bad_priority();
      test_priority_order();
      test_fill_and_drain(6);
      test_random_mix(17, 100);

      req_bus.valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("multilevel_priority_queue_top_tb OK");
      else
         $display("multilevel_priority_queue_top_tb NOT OK");
      $finish;
   end

endmodule

### multilevel_priority_queue_top.f
sv/mpq_pkg.sv
sv/mpq_if.sv
sv/mpq_ram.sv
sv/mpq_ctrl.sv
sv/mpq_datapath.sv
sv/multilevel_priority_queue_top.sv
sim/multilevel_priority_queue_top_tb.sv
